FILE: rtl/color_ping_pong_fade_defines.svh
// Assertion macros used by the checker file of the colour fade block.
`ifndef COLOR_PING_PONG_FADE_DEFINES_SVH
`define COLOR_PING_PONG_FADE_DEFINES_SVH

// Same-cycle implication, switched off while reset is high.
`define CPF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off while reset is high.
`define CPF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is checked during reset as well.
`define CPF_ASSERT_ALWAYS_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/cpf_pkg.sv
package cpf_pkg;

  localparam int REG_INDEX_BITS = 3;

  localparam logic [REG_INDEX_BITS-1:0] REG_BASE_COLOR  = 3'd0;
  localparam logic [REG_INDEX_BITS-1:0] REG_GOAL_COLOR  = 3'd1;
  localparam logic [REG_INDEX_BITS-1:0] REG_DURATION    = 3'd2;
  localparam logic [REG_INDEX_BITS-1:0] REG_SPEED       = 3'd3;
  localparam logic [REG_INDEX_BITS-1:0] REG_START_DELAY = 3'd4;
  localparam logic [REG_INDEX_BITS-1:0] REG_END_DELAY   = 3'd5;
  localparam logic [REG_INDEX_BITS-1:0] REG_LOOP_ENABLE = 3'd6;

  localparam int SPEED_BITS = 16;
  localparam int SPEED_FRAC = 8;
  localparam logic [SPEED_BITS-1:0] SPEED_UNITY = 16'd256;

  localparam int LANES = 4;

endpackage

FILE: rtl/cpf_if.sv
interface cpf_frame_if #(
  parameter int TIME_BITS = 16
);
  logic                 valid;
  logic                 ready;
  logic [TIME_BITS-1:0] frame_time;

  modport source (output valid, output frame_time, input ready);
  modport sink (input valid, input frame_time, output ready);
endinterface

interface cpf_color_if #(
  parameter int CHANNEL_BITS = 8
);
  logic                    valid;
  logic                    ready;
  logic [CHANNEL_BITS-1:0] red;
  logic [CHANNEL_BITS-1:0] green;
  logic [CHANNEL_BITS-1:0] blue;
  logic [CHANNEL_BITS-1:0] alpha;
  logic                    finished;

  modport source (output valid, output red, output green, output blue, output alpha,
                  output finished, input ready);
  modport sink (input valid, input red, input green, input blue, input alpha,
                input finished, output ready);
endinterface

FILE: rtl/color_ping_pong_fade.sv
// Ping-pong RGBA colour fade, advanced once per display frame.
// The frame channel carries the ticks since the previous frame; each transfer
// on it is one frame. The colour channel returns the colour at the start of
// that frame and the finished flag. While the start delay is pending a frame
// gives no colour and the block stays ready.
// Once the fade has completed without looping, the goal colour is returned
// through the done state without the multiply and divide.
// A fading frame runs a bit-serial
// 16-step multiply for the speed product and the four channel products,
// then a CHANNEL_BITS-step restoring divide by the duration in four lanes.
// A new frame is taken only once the colour of the last one is in the output
// register. A finished colour waits there, so the next frame can be taken
// while the receiver stalls; a colour that finds that register still full
// waits until it is free. The user must write registers through the plain
// write port only while the block is idle; the block itself does not
// enforce this. Reset loads the register defaults and clears the fade
// state, so the fade restarts from the base colour.
module color_ping_pong_fade #(
  parameter int TIME_BITS = 16,
  parameter int CHANNEL_BITS = 8,
  localparam int CFG_BITS = (4 * CHANNEL_BITS > TIME_BITS)
                            ? ((4 * CHANNEL_BITS > cpf_pkg::SPEED_BITS)
                               ? 4 * CHANNEL_BITS : cpf_pkg::SPEED_BITS)
                            : ((TIME_BITS > cpf_pkg::SPEED_BITS)
                               ? TIME_BITS : cpf_pkg::SPEED_BITS)
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               write_enable,
  input  logic [cpf_pkg::REG_INDEX_BITS-1:0] reg_index,
  input  logic [CFG_BITS-1:0]                write_data,
  cpf_frame_if.sink                          frame,
  cpf_color_if.source                        color
);

  localparam int TB = TIME_BITS;
  localparam int CB = CHANNEL_BITS;
  localparam int SB = cpf_pkg::SPEED_BITS;
  localparam int NL = cpf_pkg::LANES;
  localparam int CW = NL * CB;
  localparam int ACC_BITS = CB + TB;
  localparam int PROD_BITS = TB + SB;
  localparam int STEP_BITS = PROD_BITS - cpf_pkg::SPEED_FRAC;
  localparam int CNT_BITS = $clog2(SB);
  localparam logic [CNT_BITS-1:0] MUL_LAST = CNT_BITS'(SB - 1);
  localparam logic [CNT_BITS-1:0] DIV_LAST = CNT_BITS'(CB - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_DONE
  } state_t;

  logic [CW-1:0] base_color;
  logic [CW-1:0] goal_color;
  logic [TB-1:0] duration;
  logic [SB-1:0] speed;
  logic [TB-1:0] start_delay;
  logic [TB-1:0] end_delay;
  logic          loop_enable;

  state_t        state;
  logic [TB-1:0] start_waited;
  logic [TB-1:0] end_waited;
  logic [TB-1:0] elapsed;
  logic          reverse_leg;
  logic          completed;
  logic          done_flag;

  logic [CNT_BITS-1:0]          cnt;
  logic [TB-1:0]                frame_time_q;
  logic [SB-1:0]                speed_sh;
  logic [PROD_BITS-1:0]         prod;
  logic [TB-1:0]                elapsed_clamp;
  logic [TB-1:0]                remain;
  logic                         hold_q;
  logic [NL-1:0][SB-1:0]        lo_sh;
  logic [NL-1:0][SB-1:0]        hi_sh;
  logic [NL-1:0][ACC_BITS-1:0]  acc;

  logic          out_valid;
  logic [CB-1:0] out_red;
  logic [CB-1:0] out_green;
  logic [CB-1:0] out_blue;
  logic [CB-1:0] out_alpha;
  logic          out_finished;

  logic [CW-1:0]               from_color;
  logic [CW-1:0]               to_color;
  logic [NL-1:0][CB-1:0]       lo_ch;
  logic [NL-1:0][CB-1:0]       hi_ch;
  logic [NL-1:0][CB-1:0]       lane_result;
  logic [NL-1:0][ACC_BITS-1:0] acc_mul_next;
  logic [NL-1:0][ACC_BITS-1:0] acc_div_next;
  logic [NL-1:0][TB:0]         div_trial;
  logic [NL-1:0][TB:0]         div_diff;
  logic [PROD_BITS-1:0]        prod_next;
  logic [TB:0]                 start_sum;
  logic [TB:0]                 end_sum;
  logic [TB:0]                 elapsed_next;
  logic [TB-1:0]               clamp_now;
  logic                        in_xfer;
  logic                        out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_color  <= '0;
      goal_color  <= '1;
      duration    <= TB'(1024);
      speed       <= cpf_pkg::SPEED_UNITY;
      start_delay <= '0;
      end_delay   <= '0;
      loop_enable <= 1'b0;
    end else if (write_enable) begin
      case (reg_index)
        cpf_pkg::REG_BASE_COLOR:  base_color  <= write_data[CW-1:0];
        cpf_pkg::REG_GOAL_COLOR:  goal_color  <= write_data[CW-1:0];
        cpf_pkg::REG_DURATION:    duration    <= write_data[TB-1:0];
        cpf_pkg::REG_SPEED:       speed       <= write_data[SB-1:0];
        cpf_pkg::REG_START_DELAY: start_delay <= write_data[TB-1:0];
        cpf_pkg::REG_END_DELAY:   end_delay   <= write_data[TB-1:0];
        cpf_pkg::REG_LOOP_ENABLE: loop_enable <= write_data[0];
        default: ;
      endcase
    end
  end

  assign frame.ready  = (state == S_IDLE);
  assign in_xfer      = frame.valid && (state == S_IDLE);
  assign out_free     = !out_valid || color.ready;

  assign from_color = reverse_leg ? goal_color : base_color;
  assign to_color   = reverse_leg ? base_color : goal_color;
  assign clamp_now  = (elapsed > duration) ? duration : elapsed;
  assign start_sum  = {1'b0, start_waited} + {1'b0, frame.frame_time};
  assign end_sum    = {1'b0, end_waited} + {1'b0, frame.frame_time};
  assign prod_next  = {prod[PROD_BITS-2:0], 1'b0}
                      + (speed_sh[SB-1] ? PROD_BITS'(frame_time_q) : '0);
  assign elapsed_next = ({{(STEP_BITS + 1 - TB){1'b0}}, elapsed}
                         + {1'b0, prod[PROD_BITS-1:cpf_pkg::SPEED_FRAC]}
                         >= (STEP_BITS + 1)'(duration))
                        ? {1'b1, {TB{1'b0}}}
                        : {1'b0, elapsed + prod[cpf_pkg::SPEED_FRAC +: TB]};

  always_comb begin
    for (int i = 0; i < NL; i++) begin
      lo_ch[i] = from_color[(NL - 1 - i) * CB +: CB];
      hi_ch[i] = to_color[(NL - 1 - i) * CB +: CB];
      acc_mul_next[i] = {acc[i][ACC_BITS-2:0], 1'b0}
                        + (lo_sh[i][SB-1] ? ACC_BITS'(remain) : '0)
                        + (hi_sh[i][SB-1] ? ACC_BITS'(elapsed_clamp) : '0);
      div_trial[i] = acc[i][ACC_BITS-1:CB-1];
      div_diff[i]  = div_trial[i] - {1'b0, duration};
      if (div_trial[i] >= {1'b0, duration}) begin
        acc_div_next[i] = {div_diff[i][TB-1:0], acc[i][CB-2:0], 1'b1};
      end else begin
        acc_div_next[i] = {div_trial[i][TB-1:0], acc[i][CB-2:0], 1'b0};
      end
      lane_result[i] = (duration == '0) ? lo_ch[i] : acc[i][CB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      start_waited <= '0;
      end_waited   <= '0;
      elapsed      <= '0;
      reverse_leg  <= 1'b0;
      completed    <= 1'b0;
      done_flag    <= 1'b0;
      out_valid    <= 1'b0;
      cnt          <= '0;
    end else begin
      if (out_valid && color.ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            if (start_waited < start_delay) begin
              start_waited <= start_sum[TB] ? '1 : start_sum[TB-1:0];
            end else if (!loop_enable && completed) begin
              if (end_waited < end_delay) begin
                end_waited <= end_sum[TB] ? '1 : end_sum[TB-1:0];
              end else begin
                done_flag <= 1'b1;
              end
              hold_q <= 1'b1;
              state  <= S_DONE;
            end else begin
              hold_q        <= 1'b0;
              frame_time_q  <= frame.frame_time;
              speed_sh      <= speed;
              prod          <= '0;
              elapsed_clamp <= clamp_now;
              remain        <= duration - clamp_now;
              for (int i = 0; i < NL; i++) begin
                lo_sh[i] <= SB'(lo_ch[i]);
                hi_sh[i] <= SB'(hi_ch[i]);
                acc[i]   <= '0;
              end
              cnt   <= '0;
              state <= S_MUL;
            end
          end
        end
        S_MUL: begin
          speed_sh <= {speed_sh[SB-2:0], 1'b0};
          prod     <= prod_next;
          for (int i = 0; i < NL; i++) begin
            lo_sh[i] <= {lo_sh[i][SB-2:0], 1'b0};
            hi_sh[i] <= {hi_sh[i][SB-2:0], 1'b0};
            acc[i]   <= acc_mul_next[i];
          end
          if (cnt == MUL_LAST) begin
            cnt   <= '0;
            state <= S_DIV;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_DIV: begin
          for (int i = 0; i < NL; i++) begin
            acc[i] <= acc_div_next[i];
          end
          if (cnt == DIV_LAST) begin
            cnt   <= '0;
            state <= S_DONE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            out_finished <= done_flag;
            if (hold_q) begin
              out_red   <= goal_color[3 * CB +: CB];
              out_green <= goal_color[2 * CB +: CB];
              out_blue  <= goal_color[CB +: CB];
              out_alpha <= goal_color[0 +: CB];
            end else begin
              out_red   <= lane_result[0];
              out_green <= lane_result[1];
              out_blue  <= lane_result[2];
              out_alpha <= lane_result[3];
              if (elapsed_next[TB]) begin
                elapsed     <= '0;
                reverse_leg <= !reverse_leg;
                completed   <= 1'b1;
              end else begin
                elapsed <= elapsed_next[TB-1:0];
              end
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign color.valid    = out_valid;
  assign color.red      = out_red;
  assign color.green    = out_green;
  assign color.blue     = out_blue;
  assign color.alpha    = out_alpha;
  assign color.finished = out_finished;

endmodule

FILE: rtl/cpf_checker.sv
`include "color_ping_pong_fade_defines.svh"

module cpf_checker #(
  parameter int CHANNEL_BITS = 8
) (
  input logic                    clk,
  input logic                    rst,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [CHANNEL_BITS-1:0] out_red,
  input logic [CHANNEL_BITS-1:0] out_green,
  input logic [CHANNEL_BITS-1:0] out_blue,
  input logic [CHANNEL_BITS-1:0] out_alpha,
  input logic                    out_finished
);

  logic [4*CHANNEL_BITS:0] out_word;
  logic                    seen_finished;
  logic                    out_stall;
  logic                    out_sticky;

  assign out_word   = {out_red, out_green, out_blue, out_alpha, out_finished};
  assign out_stall  = out_valid && !out_ready;
  assign out_sticky = out_valid && seen_finished;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_finished <= 1'b0;
    end else if (out_valid && out_ready && out_finished) begin
      seen_finished <= 1'b1;
    end
  end

  // A colour offered to a stalled receiver stays offered and unchanged.
  `CPF_ASSERT_NEXT(a_valid_held, out_stall, out_valid, "colour withdrawn while stalled")
  `CPF_ASSERT_NEXT(a_word_held, out_stall, $stable(out_word), "colour changed while stalled")

  // Reset empties the output register.
  `CPF_ASSERT_ALWAYS_NEXT(a_reset_empty, rst, !out_valid, "colour offered after reset")

  // Once a finished colour has been transferred, every later one is finished.
  `CPF_ASSERT_NOW(a_finished_sticky, out_sticky, out_finished, "finished flag dropped")

endmodule

bind color_ping_pong_fade cpf_checker #(
  .CHANNEL_BITS(CHANNEL_BITS)
) u_cpf_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (color.valid),
  .out_ready    (color.ready),
  .out_red      (color.red),
  .out_green    (color.green),
  .out_blue     (color.blue),
  .out_alpha    (color.alpha),
  .out_finished (color.finished)
);
